// ===== sv/can_adapter_frame_deframer_assert.svh =====
// Assertion macros for the frame deframer.
// Included by the top level; depends on nothing else.
`ifndef CAN_ADAPTER_FRAME_DEFRAMER_ASSERT_SVH
`define CAN_ADAPTER_FRAME_DEFRAMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CAD_ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CAD_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/cad_pkg.sv =====
// Shared types and constants of the frame deframer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package cad_pkg;

	// Frame geometry.
	localparam int FRAME_LEN = 20;
	localparam int MAX_DATA  = 8;
	localparam int FILL_W    = 5;

	// Register reset values.
	localparam logic [7:0] HEADER_FIRST_RST  = 8'hAA;
	localparam logic [7:0] HEADER_SECOND_RST = 8'h55;
	localparam logic [7:0] DATA_COMMAND_RST  = 8'h01;

	// Register indexes on the configuration port (word address).
	localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] REG_DATA_COMMAND  = 2'd2;

	// Configuration seen by the front end.
	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] data_command;
	} cfg_t;

	// One decoded frame; frame_id sits in the lowest bits.
	typedef struct packed {
		logic [63:0] payload;
		logic [3:0]  data_count;
		logic [31:0] frame_id;
	} frame_t;

	// Status of the front end, for checking.
	typedef struct packed {
		logic              push;
		logic [FILL_W-1:0] fill;
	} front_stat_t;

endpackage

// ===== sv/cad_front.sv =====
// Front end of the frame deframer: byte window, running checksum and frame check.
// Depends on cad_pkg.
`timescale 1ns / 1ps

module cad_front
	import cad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        q_full,
	output logic        push,
	output frame_t      frame,
	output front_stat_t stat
);

	logic [7:0]        win_q [FRAME_LEN];
	logic [7:0]        sum_q;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        sum_next;
	logic              accept;
	logic              complete;
	logic              match;
	logic [3:0]        count;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// The window after this byte is win_q[1..19] followed by the new byte.
	// Sum of its bytes 2 to 18 slides by one entry each transaction.
	assign sum_next = sum_q - win_q[2] + win_q[FRAME_LEN-1];
	assign complete = (fill_q == FILL_W'(FRAME_LEN - 1));
	assign match    = (win_q[1] == cfg.header_first) && (win_q[2] == cfg.header_second)
		&& (win_q[3] == cfg.data_command) && (in_byte == sum_next);
	assign push     = accept && complete && match;

	// Frame fields taken from the window as it will be after the shift.
	always_comb begin
		if (win_q[10] > 8'(MAX_DATA)) begin
			count = 4'(MAX_DATA);
		end else begin
			count = win_q[10][3:0];
		end
		frame.frame_id   = {win_q[9], win_q[8], win_q[7], win_q[6]};
		frame.data_count = count;
		for (int i = 0; i < MAX_DATA; i++) begin
			frame.payload[8*i +: 8] = (4'(i) < count) ? win_q[11 + i] : 8'h00;
		end
	end

	// Shift register and checksum advance on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FRAME_LEN; i++) begin
				win_q[i] <= 8'h00;
			end
			sum_q <= 8'h00;
		end else if (accept) begin
			for (int i = 0; i < FRAME_LEN - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[FRAME_LEN-1] <= in_byte;
			sum_q              <= sum_next;
		end
	end

	// Fill level: a match empties the window, a failed check keeps it one short.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (complete) begin
				if (match) begin
					fill_q <= '0;
				end
			end else begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign stat.push = push;
	assign stat.fill = fill_q;

endmodule

// ===== sv/cad_fifo.sv =====
// Short frame queue between the front end and the output stage.
// Depends on cad_pkg.
`timescale 1ns / 1ps

module cad_fifo
	import cad_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t wr_frame,
	output logic   full,
	input  logic   pop,
	output logic   not_empty,
	output frame_t rd_frame
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_t             entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_frame  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_frame;
		end
	end

	// Pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== sv/cad_back.sv =====
// Output stage of the frame deframer: a register that drives the result stream.
// Depends on cad_pkg.
`timescale 1ns / 1ps

module cad_back
	import cad_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   q_not_empty,
	input  frame_t q_frame,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output frame_t out_frame
);

	logic   valid_q;
	frame_t frame_q;

	// Load a new frame when the register is empty or being taken.
	assign pop       = q_not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_frame = frame_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= q_frame;
		end
	end

endmodule

// ===== sv/can_adapter_frame_deframer.sv =====
// Frame deframer for a serial link: one received byte in per transaction on the
// slave stream, one decoded data frame out per transaction on the master stream.
// Header bytes and the data command are set over the APB port at words 0, 1, 2.
// The front end keeps a 20-byte shift window with a running checksum and checks
// it once 20 bytes have arrived since the last frame; a failed check drops the
// oldest byte and the next byte is checked again.
// Throughput: one byte per cycle while the queue has room; the window shift
// and the checksum update are one subtract and add per byte.
// A frame is written into the queue on the edge that accepts its last byte,
// then moves into the output register that drives m_tdata once that register
// is empty or being taken.
// Decoded frames wait in a short queue of FIFO_DEPTH entries ahead of the output
// register. When the receiver stalls and the queue is full, s_tready falls and
// bytes wait upstream; nothing is lost.
// Reset clears the window, the fill level, the queue and the output valid, and
// returns the registers to 0xAA, 0x55 and 0x01.
// Depends on cad_pkg, cad_front, cad_fifo, cad_back and the assertion macros.
`timescale 1ns / 1ps

`include "can_adapter_frame_deframer_assert.svh"

module can_adapter_frame_deframer
	import cad_pkg::*;
#(
	parameter int FIFO_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	// Byte stream in.
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] rx_byte
	// Frame stream out.
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata,   // [31:0] frame_id, [35:32] data_count,
	                                // [99:36] payload, [103:100] zero
	// Configuration.
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	cfg_t        cfg_q;
	logic        cfg_wr;
	logic        front_push;
	frame_t      front_frame;
	front_stat_t front_stat;
	logic        q_full;
	logic        q_not_empty;
	logic        q_pop;
	frame_t      q_frame;
	frame_t      out_frame;

	// Register file.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first  <= HEADER_FIRST_RST;
			cfg_q.header_second <= HEADER_SECOND_RST;
			cfg_q.data_command  <= DATA_COMMAND_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_HEADER_FIRST:  cfg_q.header_first  <= pwdata[7:0];
				REG_HEADER_SECOND: cfg_q.header_second <= pwdata[7:0];
				REG_DATA_COMMAND:  cfg_q.data_command  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HEADER_FIRST:  prdata = {24'h0, cfg_q.header_first};
			REG_HEADER_SECOND: prdata = {24'h0, cfg_q.header_second};
			REG_DATA_COMMAND:  prdata = {24'h0, cfg_q.data_command};
			default:           prdata = 32'h0;
		endcase
	end

	cad_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.q_full   (q_full),
		.push     (front_push),
		.frame    (front_frame),
		.stat     (front_stat)
	);

	cad_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.wr_frame  (front_frame),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_frame  (q_frame)
	);

	cad_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_frame     (q_frame),
		.pop         (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_frame   (out_frame)
	);

	assign m_tdata = {4'h0, out_frame};

	// Checks.
	`CAD_ASSERT_NOW(a_no_queue_overflow, clk, arst_n, front_push, !q_full, "frame pushed into a full queue")
	`CAD_ASSERT_NEXT(a_match_empties_window, clk, arst_n, front_stat.push, front_stat.fill == '0, "window not emptied after a frame")
	`CAD_ASSERT_NOW(a_count_clamped, clk, arst_n, m_tvalid, m_tdata[35:32] <= 4'(MAX_DATA), "data count above eight")

endmodule

// ===== bench/tb_can_adapter_frame_deframer.sv =====
// Self-checking bench for the frame deframer: random byte streams with framed,
// corrupted and truncated data, checked against a behavioural predictor.
// Depends on cad_pkg and the can_adapter_frame_deframer top level only.
`timescale 1ns / 1ps

module tb_can_adapter_frame_deframer;
	import cad_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 8;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = '0;    // [7:0] rx_byte
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [103:0] m_tdata;         // [31:0] frame_id, [35:32] data_count,
	                               // [99:36] payload, [103:100] zero
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [3:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	can_adapter_frame_deframer i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock: 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: configuration copy, byte window and fill level.
	cfg_t        cfg = '{header_first: HEADER_FIRST_RST, header_second: HEADER_SECOND_RST,
	                     data_command: DATA_COMMAND_RST};
	logic [7:0]  win [FRAME_LEN];
	int unsigned fill = 0;

	logic [7:0]  bytes_to_send [$];
	frame_t      frames_due [$];

	int errors = 0;
	int bytes_sent = 0;
	int frames_seen = 0;
	int input_stalls = 0;
	int settings = 0;

	// Sender and receiver pacing, set per phase.
	int          max_burst = 8;
	int          max_gap = 3;
	int          burst_left = 0;
	int          gap_left = 0;
	bit          byte_taken = 1'b0;
	logic [15:0] ready_pat = 16'hFFFF;
	bit          hold_req = 1'b0;
	int          hold_left = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	// Append one byte to the window, check a full window and queue any frame.
	task automatic deframe_byte(input logic [7:0] b);
		frame_t     f;
		logic [7:0] sum;
		int         n;
		if (fill < FRAME_LEN) begin
			win[fill] = b;
			fill++;
		end
		if (fill < FRAME_LEN)
			return;
		sum = '0;
		for (int i = 2; i < FRAME_LEN - 1; i++)
			sum += win[i];
		if (win[0] == cfg.header_first && win[1] == cfg.header_second &&
				win[2] == cfg.data_command && win[FRAME_LEN - 1] == sum) begin
			f.frame_id = {win[8], win[7], win[6], win[5]};
			n = (win[9] > MAX_DATA) ? MAX_DATA : int'(win[9]);
			f.data_count = n[3:0];
			f.payload = '0;
			for (int i = 0; i < n; i++)
				f.payload[8*i +: 8] = win[10 + i];
			frames_due = {frames_due, f};
			fill = 0;
		end else begin
			// Resynchronise: drop the oldest byte.
			for (int i = 0; i < FRAME_LEN - 1; i++)
				win[i] = win[i + 1];
			win[FRAME_LEN - 1] = '0;
			fill = FRAME_LEN - 1;
		end
	endtask

	// Input side: predict on every accepted byte.
	always @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			deframe_byte(s_tdata);
			void'(bytes_to_send.pop_front());
			bytes_sent++;
			byte_taken = 1'b1;
		end
		if (s_tvalid && !s_tready)
			input_stalls++;
	end

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || byte_taken) begin
			byte_taken = 1'b0;
			if (gap_left > 0) begin
				s_tvalid <= 1'b0;
				gap_left--;
			end else if (bytes_to_send.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= bytes_to_send[0];
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, max_burst);
					gap_left = $urandom_range(0, max_gap);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: rotating stall pattern, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ready_pat[0];
		end
		ready_pat = {ready_pat[0], ready_pat[15:1]};
	end

	// Output side: compare each frame transaction with the oldest prediction.
	always @(posedge clk) begin
		frame_t got;
		frame_t want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[99:0];
			frames_seen++;
			if (frames_due.size() == 0) begin
				report_mismatch("unexpected frame id", 64'(got.frame_id), '0);
			end else begin
				want = frames_due.pop_front();
				if (got.frame_id !== want.frame_id)
					report_mismatch("frame_id", 64'(got.frame_id), 64'(want.frame_id));
				if (got.data_count !== want.data_count)
					report_mismatch("data_count", 64'(got.data_count),
						64'(want.data_count));
				if (got.payload !== want.payload)
					report_mismatch("payload", got.payload, want.payload);
			end
			if (m_tdata[103:100] !== 4'b0)
				report_mismatch("tdata padding", 64'(m_tdata[103:100]), '0);
		end
	end

	// One APB transfer: setup cycle, then access cycle until pready.
	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write a register, mirror it, and read it back where it exists.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		apb_access(1'b1, idx, value, rd);
		case (idx)
			REG_HEADER_FIRST: cfg.header_first = value[7:0];
			REG_HEADER_SECOND: cfg.header_second = value[7:0];
			REG_DATA_COMMAND: cfg.data_command = value[7:0];
			default: ;
		endcase
		settings++;
		if (idx != REG_UNUSED) begin
			apb_access(1'b0, idx, '0, rd);
			if (rd !== {24'b0, value[7:0]})
				report_mismatch("register readback", 64'(rd), 64'({24'b0, value[7:0]}));
		end
	endtask

	// Queue the first keep bytes of a frame built for the current settings.
	task automatic queue_frame(input logic [31:0] id, input logic [7:0] count,
			input logic [63:0] data, input bit corrupt, input int keep);
		logic [7:0] fr [FRAME_LEN];
		logic [7:0] sum;
		int         pos;
		fr[0] = cfg.header_first;
		fr[1] = cfg.header_second;
		fr[2] = cfg.data_command;
		fr[3] = 8'($urandom);
		fr[4] = 8'($urandom);
		for (int i = 0; i < 4; i++)
			fr[5 + i] = id[8*i +: 8];
		fr[9] = count;
		for (int i = 0; i < MAX_DATA; i++)
			fr[10 + i] = data[8*i +: 8];
		fr[18] = 8'($urandom);
		sum = '0;
		for (int i = 2; i < FRAME_LEN - 1; i++)
			sum += fr[i];
		fr[FRAME_LEN - 1] = sum;
		if (corrupt) begin
			pos = $urandom_range(0, FRAME_LEN - 1);
			fr[pos][$urandom_range(0, 7)] ^= 1'b1;
		end
		for (int i = 0; i < keep; i++)
			bytes_to_send = {bytes_to_send, fr[i]};
	endtask

	// Wait until every byte is taken and every frame has come out.
	task automatic wait_idle();
		while (bytes_to_send.size() > 0 || frames_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// A mix of good frames, corrupted frames, noise and truncated frames.
	task automatic run_phase(input int n_bytes, input int gap, input logic [15:0] pat);
		int          r;
		int          k;
		logic [7:0]  count;
		logic [31:0] id;
		max_gap = gap;
		ready_pat = pat;
		while (n_bytes > 0) begin
			r = $urandom_range(0, 99);
			k = $urandom_range(0, 99);
			if (k < 70)
				count = 8'($urandom_range(0, MAX_DATA));
			else if (k < 85)
				count = 8'($urandom_range(MAX_DATA + 1, 255));
			else
				count = (k < 90) ? 8'h00 : (k < 95) ? 8'hFF : 8'(MAX_DATA + 1);
			id = ($urandom_range(0, 9) == 0) ? {32{k[0]}} : $urandom;
			if (r < 65) begin
				queue_frame(id, count, {$urandom, $urandom}, 1'b0, FRAME_LEN);
				n_bytes -= FRAME_LEN;
			end else if (r < 80) begin
				queue_frame(id, count, {$urandom, $urandom}, 1'b1, FRAME_LEN);
				n_bytes -= FRAME_LEN;
			end else if (r < 90) begin
				k = $urandom_range(1, 6);
				repeat (k) bytes_to_send = {bytes_to_send, 8'($urandom)};
				n_bytes -= k;
			end else begin
				k = $urandom_range(1, FRAME_LEN - 1);
				queue_frame(id, count, {$urandom, $urandom}, 1'b0, k);
				n_bytes -= k;
			end
		end
		wait_idle();
	endtask

	// Main sequence: reset, directed bytes, then phases with different settings.
	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Two noise bytes force two failed checks before an oversized-count frame lines up.
		bytes_to_send = {bytes_to_send, 8'h00};
		bytes_to_send = {bytes_to_send, 8'hFF};
		queue_frame(32'hFFFF_FFFF, 8'hFF, '1, 1'b0, FRAME_LEN);
		wait_idle();

		run_phase(180, 3, 16'hB5E7);

		// All-zero settings, written with junk in the upper bits.
		write_reg(REG_HEADER_FIRST, 32'hFFFF_FF00);
		write_reg(REG_HEADER_SECOND, 32'hA5A5_A500);
		write_reg(REG_DATA_COMMAND, 32'h8000_0000);
		write_reg(REG_UNUSED, $urandom);
		run_phase(180, 0, 16'hFFFF);

		// All-ones settings under heavy idling on both sides.
		write_reg(REG_HEADER_FIRST, 32'h0000_00FF);
		write_reg(REG_HEADER_SECOND, 32'h0000_00FF);
		write_reg(REG_DATA_COMMAND, 32'h0000_00FF);
		run_phase(180, 8, 16'h1111);

		// Random settings.
		repeat (2) begin
			write_reg(REG_HEADER_FIRST, $urandom);
			write_reg(REG_HEADER_SECOND, $urandom);
			write_reg(REG_DATA_COMMAND, $urandom);
			run_phase(180, $urandom_range(0, 5), 16'($urandom));
		end

		// Back-pressure: long receiver hold-off while good frames arrive back to back.
		max_gap = 0;
		ready_pat = 16'hFFFF;
		hold_req = 1'b1;
		repeat (HOLD_CYCLES / FRAME_LEN)
			queue_frame($urandom, 8'($urandom_range(0, MAX_DATA)), {$urandom, $urandom},
				1'b0, FRAME_LEN);
		wait_idle();

		// Reset values again, after a write to the unknown address.
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		write_reg(REG_HEADER_FIRST, 32'(HEADER_FIRST_RST));
		write_reg(REG_HEADER_SECOND, 32'(HEADER_SECOND_RST));
		write_reg(REG_DATA_COMMAND, 32'(DATA_COMMAND_RST));
		run_phase(180, 2, 16'h7F3D);

		$display("Run covered %0d bytes in, %0d frames out and %0d register writes.",
			bytes_sent, frames_seen, settings);
		$display("The byte input was held back for %0d cycles by output back-pressure.",
			input_stalls);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog for a stalled run.
	initial begin
		#5_000_000;
		$display("Timeout with %0d bytes and %0d frames outstanding.",
			bytes_to_send.size(), frames_due.size());
		$display("Verification failed");
		$finish;
	end

endmodule

// ===== can_adapter_frame_deframer.f =====
+incdir+sv
sv/cad_pkg.sv
sv/cad_front.sv
sv/cad_fifo.sv
sv/cad_back.sv
sv/can_adapter_frame_deframer.sv
bench/tb_can_adapter_frame_deframer.sv
